>>> rtl/gtb_pkg.sv
package gtb_pkg;

   localparam int FRAC_BITS_DEFAULT  = 12;
   localparam int TANH_DEPTH_DEFAULT = 256;

   // result buffer, holds every transaction in flight
   localparam int FIFO_DEPTH = 16;

   // q2.30 constants
   localparam logic signed [31:0] K_SQRT2PI = 32'sd856722022;
   localparam logic signed [31:0] K_CUBIC   = 32'sd48012366;
   localparam logic signed [31:0] K_POLY    = 32'sd144037097;
   localparam logic [63:0]        Q30_ONE   = 64'd1073741824;

   typedef struct packed {
      logic signed [15:0] grad_in;
      logic               saturated;
   } rsp_item_type;

   // shift right by s, round to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_away(input logic signed [63:0] v,
                                                   input int unsigned s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      if (v[63]) begin
         half = half - 64'sd1;
      end
      return (v + half) >>> s;
   endfunction

endpackage

>>> rtl/gtb_req_if.sv
interface gtb_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] grad_out;
   logic signed [15:0] x_value;

   modport source (output valid, output grad_out, output x_value, input ready);
   modport sink (input valid, input grad_out, input x_value, output ready);
endinterface

>>> rtl/gtb_rsp_if.sv
interface gtb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] grad_in;
   logic               saturated;

   modport source (output valid, output grad_in, output saturated, input ready);
   modport sink (input valid, input grad_in, input saturated, output ready);
endinterface

>>> rtl/gtb_tanh_rom.sv
module gtb_tanh_rom #(
   parameter int TANH_TABLE_DEPTH = gtb_pkg::TANH_DEPTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic [$clog2(TANH_TABLE_DEPTH + 1) - 1:0] rd_addr,
   output logic [30:0]                               sample_lo,
   output logic [30:0]                               sample_hi
);

   localparam int AW = $clog2(TANH_TABLE_DEPTH + 1);

   typedef logic [30:0] rom_type [TANH_TABLE_DEPTH + 1];

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(8k/depth) in q2.30 through exp(-k/depth) raised to the 16th power
   function automatic logic [30:0] tanh_sample(input logic [63:0] k);
      logic [63:0]        term;
      logic [63:0]        d;
      logic [63:0]        e;
      logic [63:0]        num;
      logic [63:0]        dd;
      logic signed [63:0] acc;
      term = gtb_pkg::Q30_ONE;
      acc  = signed'(gtb_pkg::Q30_ONE);
      for (int n = 1; n <= 30; n++) begin
         d    = 64'(n) * 64'(TANH_TABLE_DEPTH);
         term = udiv64(term * k + (d >> 1), d);
         if (n[0]) begin
            acc = acc - signed'(term);
         end else begin
            acc = acc + signed'(term);
         end
      end
      if (acc < 0) begin
         acc = '0;
      end
      e = unsigned'(acc);
      for (int j = 0; j < 4; j++) begin
         e = (e * e + (64'd1 << 29)) >> 30;
      end
      num = (gtb_pkg::Q30_ONE - e) << 30;
      dd  = gtb_pkg::Q30_ONE + e;
      return 31'(udiv64(num + (dd >> 1), dd));
   endfunction

   function automatic rom_type build_rom();
      rom_type rom;
      for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
         rom[k] = tanh_sample(64'(k));
      end
      return rom;
   endfunction

   localparam rom_type TANH_ROM = build_rom();

   logic [AW-1:0] addr_hi;
   logic [30:0]   lo_ff;
   logic [30:0]   hi_ff;

   assign addr_hi = rd_addr + AW'(1);

   always_ff @(posedge clock) begin
      lo_ff <= TANH_ROM[rd_addr];
      hi_ff <= TANH_ROM[addr_hi];
   end

   assign sample_lo = lo_ff;
   assign sample_hi = hi_ff;

endmodule

>>> rtl/gtb_rsp_fifo.sv
module gtb_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   input  gtb_pkg::rsp_item_type wr_item,
   gtb_rsp_if.source             rsp_if
);

   localparam int PW = $clog2(gtb_pkg::FIFO_DEPTH);

   gtb_pkg::rsp_item_type mem [gtb_pkg::FIFO_DEPTH];

   logic [PW:0]           wr_ptr_in, wr_ptr_ff;
   logic [PW:0]           rd_ptr_in, rd_ptr_ff;
   logic                  rd_acc;
   gtb_pkg::rsp_item_type head;

   assign head          = mem[rd_ptr_ff[PW-1:0]];
   assign rsp_if.valid     = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_if.grad_in   = head.grad_in;
   assign rsp_if.saturated = head.saturated;
   assign rd_acc        = rsp_if.valid && rsp_if.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (PW + 1)'(wr_valid);
      rd_ptr_in = rd_ptr_ff + (PW + 1)'(rd_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem[wr_ptr_ff[PW-1:0]] <= wr_item;
      end
   end

endmodule

>>> rtl/gelu_tanh_backward_top.sv
// gelu backward, tanh form, one element per transaction
// req_if carries grad_out and x_value, both signed q3.12 (FRAC_BITS fraction
// bits); rsp_if returns grad_in, saturated to 16 bits, and a saturated flag.
// both channels move a transaction on a clock edge with valid and ready high.
// a transaction passes a 12 stage pipeline that never stalls, then lands in a
// 16 entry result buffer. one request is taken per cycle while fewer than
// 16 transactions are in flight (in the pipeline or waiting in the buffer).
// tanh comes from a table of TANH_TABLE_DEPTH+1 samples with linear
// interpolation, read through a registered rom port in pipeline stage 5.
// when rsp_if.ready is low results collect in the buffer and req_if.ready
// drops once 16 transactions are outstanding; nothing is lost or repeated.
// reset is synchronous: it empties the pipeline and the buffer, and
// req_if.ready stays low while reset is high.
module gelu_tanh_backward_top #(
   parameter int FRAC_BITS        = gtb_pkg::FRAC_BITS_DEFAULT,
   parameter int TANH_TABLE_DEPTH = gtb_pkg::TANH_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   gtb_req_if.sink   req_if,
   gtb_rsp_if.source rsp_if
);

   localparam int PIPE_DEPTH = 12;
   localparam int CW         = $clog2(gtb_pkg::FIFO_DEPTH + 1);

   localparam int W_XX  = 32;
   localparam int W_X2  = 32 - FRAC_BITS;
   localparam int W_X2X = W_X2 + 16;
   localparam int W_X3  = 47 - 2 * FRAC_BITS;
   localparam int W_X3A = W_X3 + 27;
   localparam int W_C   = 43 - 2 * FRAC_BITS;
   localparam int W_XC  = ((W_C > 16) ? W_C : 16) + 1;
   localparam int W_XCS = W_XC + 31;
   localparam int W_U   = W_XC;
   localparam int W_A   = FRAC_BITS + 3;
   localparam int AW    = $clog2(TANH_TABLE_DEPTH + 1);
   localparam int W_PA  = W_A + AW;
   localparam int W_X2B = W_X2 + 29;
   localparam int W_P   = ((FRAC_BITS > 28 - FRAC_BITS) ? FRAC_BITS : 28 - FRAC_BITS) + 2;
   localparam int W_T   = FRAC_BITS + 2;
   localparam int W_DP  = 32 + W_A + 1;
   localparam int W_V   = 33;
   localparam int W_TT  = 2 * W_T;
   localparam int W_PQ  = W_P + W_T;
   localparam int W_QS  = W_P + 31;
   localparam int W_XP  = 16 + W_P;
   localparam int W_XPR = 17 + W_P - FRAC_BITS;
   localparam int W_SUM = W_XPR + 1;
   localparam int W_GS  = 16 + W_SUM;
   localparam int W_RES = W_GS - FRAC_BITS + 1;

   localparam logic signed [W_T-1:0] T_ONE = W_T'(2 ** FRAC_BITS);

   // credit count and valid bits
   logic                  in_acc;
   logic                  out_acc;
   logic [CW-1:0]         cnt_in, cnt_ff;
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;

   // stage 1
   logic signed [15:0]      s1_g_ff, s1_x_ff;
   logic signed [W_XX-1:0]  s1_xx_in, s1_xx_ff;
   // stage 2
   logic signed [15:0]      s2_g_ff, s2_x_ff;
   logic signed [W_X2-1:0]  s2_x2_in, s2_x2_ff;
   logic signed [W_X2X-1:0] s2_x2x_in, s2_x2x_ff;
   // stage 3
   logic signed [15:0]      s3_g_ff, s3_x_ff;
   logic signed [W_X3-1:0]  s3_x3;
   logic signed [W_X3A-1:0] s3_x3a_in, s3_x3a_ff;
   logic signed [W_X2B-1:0] s3_x2b_in, s3_x2b_ff;
   // stage 4
   logic signed [15:0]      s4_g_ff, s4_x_ff;
   logic signed [W_X2B-1:0] s4_x2b_ff;
   logic signed [W_C-1:0]   s4_c;
   logic signed [W_XC-1:0]  s4_xc;
   logic signed [W_XCS-1:0] s4_xcs_in, s4_xcs_ff;
   // stage 5
   logic signed [15:0]      s5_g_ff, s5_x_ff;
   logic signed [W_U-1:0]   s5_u;
   logic [W_U-1:0]          s5_abs;
   logic [W_PA-1:0]         s5_p;
   logic [AW-1:0]           s5_idx;
   logic [W_A-1:0]          s5_frac_in, s5_frac_ff;
   logic                    s5_neg_in, s5_neg_ff;
   logic                    s5_big_in, s5_big_ff;
   logic signed [W_P-1:0]   s5_poly_in, s5_poly_ff;
   logic [30:0]             s5_lo, s5_hi;
   // stage 6
   logic signed [15:0]      s6_g_ff, s6_x_ff;
   logic signed [W_P-1:0]   s6_poly_ff;
   logic                    s6_neg_ff, s6_big_ff;
   logic [30:0]             s6_lo_ff;
   logic signed [31:0]      s6_diff;
   logic signed [W_DP-1:0]  s6_prod_in, s6_prod_ff;
   // stage 7
   logic signed [15:0]      s7_g_ff, s7_x_ff;
   logic signed [W_P-1:0]   s7_poly_ff;
   logic signed [W_V-1:0]   s7_v;
   logic signed [W_T-1:0]   s7_mag;
   logic signed [W_T-1:0]   s7_t_in, s7_t_ff;
   // stage 8
   logic signed [15:0]      s8_g_ff, s8_x_ff;
   logic signed [W_P-1:0]   s8_poly_ff;
   logic signed [W_T:0]     s8_one_t;
   logic signed [W_T-1:0]   s8_cdf_in, s8_cdf_ff;
   logic signed [W_TT-1:0]  s8_tt_in, s8_tt_ff;
   // stage 9
   logic signed [15:0]      s9_g_ff, s9_x_ff;
   logic signed [W_T-1:0]   s9_cdf_ff;
   logic signed [W_T-1:0]   s9_t2;
   logic signed [W_T-1:0]   s9_omt;
   logic signed [W_PQ-1:0]  s9_pq_in, s9_pq_ff;
   // stage 10
   logic signed [15:0]      s10_g_ff, s10_x_ff;
   logic signed [W_T-1:0]   s10_cdf_ff;
   logic signed [W_P-1:0]   s10_q;
   logic signed [W_QS-1:0]  s10_qs_in, s10_qs_ff;
   // stage 11
   logic signed [15:0]      s11_g_ff;
   logic signed [W_T-1:0]   s11_cdf_ff;
   logic signed [W_P-1:0]   s11_pdf;
   logic signed [W_XP-1:0]  s11_xp_in, s11_xp_ff;
   // stage 12
   logic signed [W_SUM-1:0] s12_sum;
   logic signed [W_GS-1:0]  s12_gs_in, s12_gs_ff;
   // buffer write
   logic signed [W_RES-1:0] res;
   gtb_pkg::rsp_item_type   res_item;

   assign req_if.ready = !reset && (cnt_ff < CW'(gtb_pkg::FIFO_DEPTH));
   assign in_acc       = req_if.valid && req_if.ready;
   assign out_acc      = rsp_if.valid && rsp_if.ready;

   always_comb begin
      cnt_in   = cnt_ff + CW'(in_acc) - CW'(out_acc);
      valid_in = {valid_ff[PIPE_DEPTH-2:0], in_acc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   gtb_tanh_rom #(
      .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
   ) u_tanh_rom (
      .clock     (clock),
      .rd_addr   (s5_idx),
      .sample_lo (s5_lo),
      .sample_hi (s5_hi)
   );

   always_comb begin
      s1_xx_in = W_XX'(req_if.x_value) * W_XX'(req_if.x_value);

      s2_x2_in  = W_X2'(gtb_pkg::rnd_away(64'(s1_xx_ff), FRAC_BITS));
      s2_x2x_in = W_X2X'(s2_x2_in) * W_X2X'(s1_x_ff);

      s3_x3     = W_X3'(gtb_pkg::rnd_away(64'(s2_x2x_ff), FRAC_BITS));
      s3_x3a_in = W_X3A'(s3_x3) * W_X3A'(gtb_pkg::K_CUBIC);
      s3_x2b_in = W_X2B'(s2_x2_ff) * W_X2B'(gtb_pkg::K_POLY);

      s4_c      = W_C'(gtb_pkg::rnd_away(64'(s3_x3a_ff), 30));
      s4_xc     = W_XC'(s3_x_ff) + W_XC'(s4_c);
      s4_xcs_in = W_XCS'(s4_xc) * W_XCS'(gtb_pkg::K_SQRT2PI);

      // table lookup address for |u|, large arguments clamp to one
      s5_u       = W_U'(gtb_pkg::rnd_away(64'(s4_xcs_ff), 30));
      s5_neg_in  = s5_u[W_U-1];
      s5_abs     = s5_neg_in ? W_U'(-s5_u) : W_U'(s5_u);
      s5_big_in  = 32'(s5_abs) >= (32'd8 << FRAC_BITS);
      s5_p       = W_PA'(s5_abs[W_A-1:0]) * W_PA'(TANH_TABLE_DEPTH);
      s5_idx     = s5_p[W_PA-1:W_A];
      s5_frac_in = s5_p[W_A-1:0];
      s5_poly_in = W_P'(T_ONE) + W_P'(gtb_pkg::rnd_away(64'(s4_x2b_ff), 30));

      s6_diff    = $signed({1'b0, s5_hi}) - $signed({1'b0, s5_lo});
      s6_prod_in = W_DP'(s6_diff) * W_DP'($signed({1'b0, s5_frac_ff}));

      s7_v   = W_V'($signed({1'b0, s6_lo_ff})) +
               W_V'(gtb_pkg::rnd_away(64'(s6_prod_ff), FRAC_BITS + 3));
      s7_mag = s6_big_ff ? T_ONE : W_T'(gtb_pkg::rnd_away(64'(s7_v), 30 - FRAC_BITS));
      s7_t_in = s6_neg_ff ? -s7_mag : s7_mag;

      s8_one_t  = (W_T + 1)'(T_ONE) + (W_T + 1)'(s7_t_ff);
      s8_cdf_in = W_T'(gtb_pkg::rnd_away(64'(s8_one_t), 1));
      s8_tt_in  = W_TT'(s7_t_ff) * W_TT'(s7_t_ff);

      s9_t2    = W_T'(gtb_pkg::rnd_away(64'(s8_tt_ff), FRAC_BITS));
      s9_omt   = T_ONE - s9_t2;
      s9_pq_in = W_PQ'(s8_poly_ff) * W_PQ'(s9_omt);

      s10_q     = W_P'(gtb_pkg::rnd_away(64'(s9_pq_ff), FRAC_BITS));
      s10_qs_in = W_QS'(s10_q) * W_QS'(gtb_pkg::K_SQRT2PI);

      s11_pdf   = W_P'(gtb_pkg::rnd_away(64'(s10_qs_ff), 31));
      s11_xp_in = W_XP'(s10_x_ff) * W_XP'(s11_pdf);

      s12_sum   = W_SUM'(s11_cdf_ff) +
                  W_SUM'(gtb_pkg::rnd_away(64'(s11_xp_ff), FRAC_BITS));
      s12_gs_in = W_GS'(s11_g_ff) * W_GS'(s12_sum);

      res = W_RES'(gtb_pkg::rnd_away(64'(s12_gs_ff), FRAC_BITS));
      priority if (res > W_RES'(32767)) begin
         res_item.grad_in   = 16'sh7FFF;
         res_item.saturated = 1'b1;
      end else if (res < W_RES'(-32768)) begin
         res_item.grad_in   = 16'sh8000;
         res_item.saturated = 1'b1;
      end else begin
         res_item.grad_in   = res[15:0];
         res_item.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_g_ff  <= req_if.grad_out;
      s1_x_ff  <= req_if.x_value;
      s1_xx_ff <= s1_xx_in;

      s2_g_ff   <= s1_g_ff;
      s2_x_ff   <= s1_x_ff;
      s2_x2_ff  <= s2_x2_in;
      s2_x2x_ff <= s2_x2x_in;

      s3_g_ff   <= s2_g_ff;
      s3_x_ff   <= s2_x_ff;
      s3_x3a_ff <= s3_x3a_in;
      s3_x2b_ff <= s3_x2b_in;

      s4_g_ff   <= s3_g_ff;
      s4_x_ff   <= s3_x_ff;
      s4_x2b_ff <= s3_x2b_ff;
      s4_xcs_ff <= s4_xcs_in;

      s5_g_ff    <= s4_g_ff;
      s5_x_ff    <= s4_x_ff;
      s5_frac_ff <= s5_frac_in;
      s5_neg_ff  <= s5_neg_in;
      s5_big_ff  <= s5_big_in;
      s5_poly_ff <= s5_poly_in;

      s6_g_ff    <= s5_g_ff;
      s6_x_ff    <= s5_x_ff;
      s6_poly_ff <= s5_poly_ff;
      s6_neg_ff  <= s5_neg_ff;
      s6_big_ff  <= s5_big_ff;
      s6_lo_ff   <= s5_lo;
      s6_prod_ff <= s6_prod_in;

      s7_g_ff    <= s6_g_ff;
      s7_x_ff    <= s6_x_ff;
      s7_poly_ff <= s6_poly_ff;
      s7_t_ff    <= s7_t_in;

      s8_g_ff    <= s7_g_ff;
      s8_x_ff    <= s7_x_ff;
      s8_poly_ff <= s7_poly_ff;
      s8_cdf_ff  <= s8_cdf_in;
      s8_tt_ff   <= s8_tt_in;

      s9_g_ff   <= s8_g_ff;
      s9_x_ff   <= s8_x_ff;
      s9_cdf_ff <= s8_cdf_ff;
      s9_pq_ff  <= s9_pq_in;

      s10_g_ff   <= s9_g_ff;
      s10_x_ff   <= s9_x_ff;
      s10_cdf_ff <= s9_cdf_ff;
      s10_qs_ff  <= s10_qs_in;

      s11_g_ff   <= s10_g_ff;
      s11_cdf_ff <= s10_cdf_ff;
      s11_xp_ff  <= s11_xp_in;

      s12_gs_ff <= s12_gs_in;
   end

   gtb_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (valid_ff[PIPE_DEPTH-1]),
      .wr_item  (res_item),
      .rsp_if   (rsp_if)
   );

endmodule

>>> test/gelu_tanh_backward_top_test.sv
`timescale 1ns / 100ps

module gelu_tanh_backward_top_test;

   localparam int FRAC   = gtb_pkg::FRAC_BITS_DEFAULT;
   localparam int DEPTH  = gtb_pkg::TANH_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   localparam longint ONE = longint'(1) << FRAC;
   localparam longint KS  = gtb_pkg::K_SQRT2PI;
   localparam longint KC  = gtb_pkg::K_CUBIC;
   localparam longint KP  = gtb_pkg::K_POLY;
   localparam longint unsigned Q30 = 64'd1073741824;

   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_MOSTLY,
      RSP_RARELY,
      RSP_BURSTY
   } rsp_mode_type;

   logic clock;
   logic reset;

   gtb_req_if req_bus ();
   gtb_rsp_if rsp_bus ();

   gelu_tanh_backward_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   longint                tanh_table [0:DEPTH];
   gtb_pkg::rsp_item_type expected_grad_q [$];
   gtb_pkg::rsp_item_type want;
   rsp_mode_type          rsp_mode = RSP_ALWAYS;
   int                    cycle_count = 0;
   int                    error_count = 0;
   int                    burst_left = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // divide by 2^s, round half away from zero
   function automatic longint round_shift(input longint v, input int unsigned s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) begin
         return (v + half) >>> s;
      end
      return -((-v + half) >>> s);
   endfunction

   // tanh(8k/DEPTH) in q2.30 from a series for exp(-k/DEPTH)
   function automatic longint tanh_sample(input longint unsigned k);
      longint unsigned term;
      longint unsigned d;
      longint unsigned e;
      longint unsigned num;
      longint unsigned dd;
      longint          sum;
      term = Q30;
      sum = longint'(Q30);
      for (int unsigned n = 1; n <= 30; n++) begin
         d = n * DEPTH;
         term = (term * k + d / 2) / d;
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      e = sum;
      repeat (4) e = (e * e + (64'd1 << 29)) >> 30;
      num = (Q30 - e) << 30;
      dd = Q30 + e;
      return longint'((num + dd / 2) / dd);
   endfunction

   function automatic longint tanh_interp(input longint u);
      longint a;
      longint t;
      longint v;
      longint frac;
      longint unsigned p;
      longint unsigned idx;
      a = (u < 0) ? -u : u;
      if (a >= (longint'(8) << FRAC)) begin
         t = ONE;
      end else begin
         p = a * DEPTH;
         idx = p >> (FRAC + 3);
         frac = longint'(p & ((64'd1 << (FRAC + 3)) - 1));
         if (idx >= DEPTH) begin
            idx = DEPTH - 1;
         end
         v = tanh_table[idx] +
             round_shift((tanh_table[idx + 1] - tanh_table[idx]) * frac, FRAC + 3);
         t = round_shift(v, 30 - FRAC);
      end
      return (u < 0) ? -t : t;
   endfunction

   function automatic gtb_pkg::rsp_item_type predict_grad(input logic signed [15:0] g,
                                                          input logic signed [15:0] x);
      gtb_pkg::rsp_item_type r;
      longint gv, xv, x2, x3, u, t, t2, cdf, poly, pdf, res;
      gv = g;
      xv = x;
      x2 = round_shift(xv * xv, FRAC);
      x3 = round_shift(x2 * xv, FRAC);
      u = round_shift((xv + round_shift(x3 * KC, 30)) * KS, 30);
      t = tanh_interp(u);
      t2 = round_shift(t * t, FRAC);
      cdf = round_shift(ONE + t, 1);
      poly = ONE + round_shift(x2 * KP, 30);
      pdf = round_shift(round_shift(poly * (ONE - t2), FRAC) * KS, 31);
      res = round_shift(gv * (cdf + round_shift(xv * pdf, FRAC)), FRAC);
      r.saturated = 1'b0;
      if (res > 32767) begin
         res = 32767;
         r.saturated = 1'b1;
      end else if (res < -32768) begin
         res = -32768;
         r.saturated = 1'b1;
      end
      r.grad_in = res[15:0];
      return r;
   endfunction

   task automatic send_item(input logic signed [15:0] g, input logic signed [15:0] x);
      req_bus.valid <= 1'b1;
      req_bus.grad_out <= g;
      req_bus.x_value <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_grad_q.push_back(predict_grad(g, x));
   endtask

   task automatic idle_cycles(input int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // bursts of random length, random gaps between them
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 60);
         idle_cycles($urandom_range(1, 10));
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_grad_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(16'sd0, 16'sd0);
      send_item(16'sd4096, 16'sd0);
      send_item(16'sd32767, 16'sd32767);
      send_item(-16'sd32768, -16'sd32768);
      send_item(16'sd32767, -16'sd32768);
      send_item(-16'sd32768, 16'sd32767);
      // positive and negative clamp near the derivative peak
      send_item(16'sd32767, 16'sd6144);
      send_item(-16'sd32768, 16'sd6144);
      send_item(-16'sd32768, -16'sd6144);
      // tanh argument just below the table end, both signs
      send_item(16'sd4096, 16'sd19800);
      send_item(16'sd4096, 16'sd19900);
      send_item(16'sd4096, -16'sd19900);
      send_item(16'sd4096, 16'sd1);
      send_item(16'sd4096, -16'sd1);
      send_item(16'sh5555, 16'shAAAA);
      send_item(16'shAAAA, 16'sh5555);
      idle_cycles(3);
      send_item(16'sd1, 16'sd4096);
      send_item(-16'sd1, -16'sd4096);
      send_item(16'sd32767, 16'sd8192);
      send_item(16'sd0, 16'sd32767);
      send_item(-16'sd32768, 16'sd0);
      wait_drained();
   endtask

   task automatic test_random_full();
      for (int i = 0; i < 400; i++) begin
         send_item(16'($urandom), 16'($urandom));
         pace_sender();
      end
      wait_drained();
   endtask

   // x where the curve bends, gradient sometimes at its extremes
   task automatic test_random_active();
      logic signed [15:0] g;
      for (int i = 0; i < 400; i++) begin
         case ($urandom_range(0, 7))
            0: g = 16'sd32767;
            1: g = -16'sd32768;
            default: g = 16'($urandom);
         endcase
         send_item(g, 16'($urandom_range(0, 49152) - 24576));
         pace_sender();
      end
      wait_drained();
   endtask

   task automatic test_saturation();
      int m;
      int xm;
      for (int i = 0; i < 100; i++) begin
         m = $urandom_range(28000, 32767);
         xm = $urandom_range(2048, 10240);
         send_item(16'($urandom_range(0, 1) ? m : -m - 1),
                   16'($urandom_range(0, 3) != 0 ? xm : -xm));
         pace_sender();
      end
      wait_drained();
   endtask

   // receiver ready pattern, switches mode now and then
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if ((cycle_count % 300) == 0) begin
         rsp_mode <= rsp_mode_type'($urandom_range(0, 3));
      end
      case (rsp_mode)
         RSP_ALWAYS: rsp_bus.ready <= 1'b1;
         RSP_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         RSP_RARELY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_bus.ready <= ((cycle_count % 24) >= 16);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_grad_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual grad_in %0d sat %0b",
                     $time, $signed(rsp_bus.grad_in), rsp_bus.saturated);
            error_count++;
         end else begin
            want = expected_grad_q.pop_front();
            if (rsp_bus.grad_in !== want.grad_in) begin
               $display("%0t: grad_in mismatch, expected %0d, actual %0d",
                        $time, $signed(want.grad_in), $signed(rsp_bus.grad_in));
               error_count++;
            end
            if (rsp_bus.saturated !== want.saturated) begin
               $display("%0t: saturated mismatch, expected %0b, actual %0b",
                        $time, want.saturated, rsp_bus.saturated);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.grad_out <= '0;
      req_bus.x_value <= '0;
      for (int k = 0; k <= DEPTH; k++) begin
         tanh_table[k] = tanh_sample(k);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_full();
      test_random_active();
      test_saturation();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_grad_q.size() != 0) begin
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
